// ----- rtl/ffdt_pkg.sv -----
// ----------------------------------------------------------------------------
// ffdt_pkg
// Shared constants, types and the sequencer microcode for the filtered
// feedback delay tap.
// ----------------------------------------------------------------------------
package ffdt_pkg;

  localparam int MAX_DELAY      = 65536;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 20;

  localparam int COEF_W     = 24;
  localparam int LEN_W      = 17;
  localparam int LEVEL_W    = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_COEF   = 5;

  localparam int POS_W  = $clog2(MAX_DELAY);
  localparam int HIST_W = SAMPLE_BITS + 8;
  localparam int MUL_W  = (COEF_W > HIST_W) ? COEF_W : HIST_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int OSH_W  = ACC_W - COEF_FRAC_BITS;
  localparam int FBT_W  = HIST_W + 3;   // feedback term after /64
  localparam int WV_W   = HIST_W + 2;   // wet term after /128

  localparam int FB_UNITY = 64;         // feedback level that means none

  localparam logic [COEF_W-1:0]  COEF_B0_RST = COEF_W'(1048576);
  localparam logic [LEN_W-1:0]   LEN_RST     = LEN_W'(1000);
  localparam logic [LEVEL_W-1:0] FB_RST      = LEVEL_W'(112);
  localparam logic [LEVEL_W-1:0] WET_RST     = LEVEL_W'(96);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0   = 3'd0,
    CFG_B1   = 3'd1,
    CFG_B2   = 3'd2,
    CFG_FB1  = 3'd3,
    CFG_FB2  = 3'd4,
    CFG_LEN  = 3'd5,
    CFG_FBL  = 3'd6,
    CFG_WET  = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE    = 3'd0,
    MUL_B0_D    = 3'd1,
    MUL_B1_IH1  = 3'd2,
    MUL_B2_IH2  = 3'd3,
    MUL_FB1_OH1 = 3'd4,
    MUL_FB2_OH2 = 3'd5,
    MUL_FB_O    = 3'd6,
    MUL_WET_O   = 3'd7
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_NO_UPD = 2'd1,
    JMP_ALWAYS = 2'd2
  } jmp_e;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_FIN  = STEP_W'(10);

  typedef struct packed {
    mul_sel_e          mul;
    acc_op_e           acc;
    logic              wait_in;
    logic              calc_o;
    logic              calc_fbt;
    logic              fin;
    jmp_e              jmp;
    logic [STEP_W-1:0] tgt;
  } ctrl_t;

  // Microcode: one control word per step.
  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '{mul: MUL_NONE, acc: ACC_HOLD, wait_in: 1'b0, calc_o: 1'b0,
           calc_fbt: 1'b0, fin: 1'b0, jmp: JMP_NEXT, tgt: STEP_IDLE};
    case (step)
      4'd0: cw.wait_in = 1'b1;
      4'd1: begin
        cw.mul = MUL_B0_D;
        cw.jmp = JMP_NO_UPD;
        cw.tgt = STEP_FIN;
      end
      4'd2: begin
        cw.mul = MUL_B1_IH1;
        cw.acc = ACC_LOAD;
      end
      4'd3: begin
        cw.mul = MUL_B2_IH2;
        cw.acc = ACC_ADD;
      end
      4'd4: begin
        cw.mul = MUL_FB1_OH1;
        cw.acc = ACC_ADD;
      end
      4'd5: begin
        cw.mul = MUL_FB2_OH2;
        cw.acc = ACC_SUB;
      end
      4'd6: cw.acc = ACC_SUB;
      4'd7: cw.calc_o = 1'b1;
      4'd8: cw.mul = MUL_FB_O;
      4'd9: begin
        cw.mul      = MUL_WET_O;
        cw.calc_fbt = 1'b1;
      end
      4'd10: begin
        cw.fin = 1'b1;
        cw.jmp = JMP_ALWAYS;
        cw.tgt = STEP_IDLE;
      end
      default: begin
        cw.jmp = JMP_ALWAYS;
        cw.tgt = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/ffdt_in_if.sv -----
// ----------------------------------------------------------------------------
// ffdt_in_if
// Sample input channel: valid/ready with the input sample and its flags.
// ----------------------------------------------------------------------------
interface ffdt_in_if;
  import ffdt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          has_input;
  logic                          want_output;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, has_input, want_output, sample_in, input ready);
  modport sink   (input valid, has_input, want_output, sample_in, output ready);
endinterface

// ----- rtl/ffdt_out_if.sv -----
// ----------------------------------------------------------------------------
// ffdt_out_if
// Wet output channel: valid/ready with the wet sample.
// ----------------------------------------------------------------------------
interface ffdt_out_if;
  import ffdt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] wet_out;

  modport source (output valid, wet_out, input ready);
  modport sink   (input valid, wet_out, output ready);
endinterface

// ----- rtl/filtered_feedback_delay_tap.sv -----
// ----------------------------------------------------------------------------
// filtered_feedback_delay_tap
// One tap of a feedback delay with a direct-form-I biquad in the loop.
// ----------------------------------------------------------------------------
// Usage notes:
//  - in_i takes one beat per sample (flags plus signed sample). out_o gives
//    one beat per input beat, the wet sample, in order.
//  - Config: cfg_we_i/cfg_idx_i/cfg_data_i, one register per cycle; write
//    only while the tap is idle. Index order: b0, b1, b2, fb1, fb2, length,
//    feedback level, wet level.
//  - A beat runs through an 11-step microcoded sequence sharing one 24x24
//    multiplier: 5 products for the biquad, one each for feedback and wet.
//    When feedback is off and no output is wanted, the beat jumps from the
//    first product step straight to the final step. Next beat is taken in
//    the cycle after the output beat is loaded, never before.
//  - The output register lets a new beat start while the last result waits;
//    a stalled receiver only holds the sequence at its final step.
//  - After reset the delay memory is zeroed by a clearing pass over all
//    65536 entries (one entry per cycle); in_i.ready stays low until done.
//    Config writes are taken during the pass.
// ----------------------------------------------------------------------------
module filtered_feedback_delay_tap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffdt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffdt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ffdt_in_if.sink                         in_i,
  ffdt_out_if.source                      out_o
);
  import ffdt_pkg::*;

  // --- configuration registers -------------------------------------------
  logic signed [COEF_W-1:0] coef_q [NUM_COEF];
  logic [LEN_W-1:0]         len_q;
  logic [LEVEL_W-1:0]       fbl_q;
  logic [LEVEL_W-1:0]       wetl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= COEF_B0_RST;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      coef_q[3] <= '0;
      coef_q[4] <= '0;
      len_q     <= LEN_RST;
      fbl_q     <= FB_RST;
      wetl_q    <= WET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_B0:  coef_q[0] <= cfg_data_i[COEF_W-1:0];
        CFG_B1:  coef_q[1] <= cfg_data_i[COEF_W-1:0];
        CFG_B2:  coef_q[2] <= cfg_data_i[COEF_W-1:0];
        CFG_FB1: coef_q[3] <= cfg_data_i[COEF_W-1:0];
        CFG_FB2: coef_q[4] <= cfg_data_i[COEF_W-1:0];
        CFG_LEN: len_q     <= cfg_data_i[LEN_W-1:0];
        CFG_FBL: fbl_q     <= cfg_data_i[LEVEL_W-1:0];
        CFG_WET: wetl_q    <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Feedback gain (level - 64), signed; off when level is unity.
  logic signed [LEVEL_W:0] fb_s;
  logic                    fb_on;
  assign fb_s  = signed'({1'b0, fbl_q}) - (LEVEL_W+1)'(FB_UNITY);
  assign fb_on = (fbl_q != LEVEL_W'(FB_UNITY));

  // Effective length: 0 counts as 1, clamp to memory depth.
  logic [POS_W:0] len_eff;
  always_comb begin
    if (len_q == '0) begin
      len_eff = (POS_W+1)'(1);
    end else if (32'(len_q) > 32'(MAX_DELAY)) begin
      len_eff = (POS_W+1)'(MAX_DELAY);
    end else begin
      len_eff = (POS_W+1)'(len_q);
    end
  end

  // --- sequencer -----------------------------------------------------------
  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             cw;
  logic              in_acc;
  logic              out_free;
  logic              fin_go;
  logic              clr_busy_q;
  logic [POS_W-1:0]  clr_cnt_q;
  logic              upd_q, want_q, has_q;

  assign cw       = ucode(step_q);
  assign in_i.ready = cw.wait_in && !clr_busy_q;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_o.valid || out_o.ready;
  assign fin_go   = cw.fin && out_free;

  always_comb begin
    step_d = step_q;
    if (cw.wait_in) begin
      if (in_acc) step_d = step_q + STEP_W'(1);
    end else if (cw.fin) begin
      if (out_free) step_d = cw.tgt;
    end else begin
      case (cw.jmp)
        JMP_NEXT:   step_d = step_q + STEP_W'(1);
        JMP_NO_UPD: step_d = upd_q ? step_q + STEP_W'(1) : cw.tgt;
        JMP_ALWAYS: step_d = cw.tgt;
        default:    step_d = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Clearing pass over the delay memory after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + POS_W'(1);
      if (&clr_cnt_q) clr_busy_q <= 1'b0;
    end
  end

  // --- beat capture and position ------------------------------------------
  logic [POS_W-1:0]              pos_q;
  logic [POS_W-1:0]              pos_eff;
  logic [POS_W:0]                pos_inc;
  logic signed [SAMPLE_BITS-1:0] x_q;

  assign pos_eff = ({1'b0, pos_q} >= len_eff) ? '0 : pos_q;
  assign pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      upd_q  <= 1'b0;
      want_q <= 1'b0;
      has_q  <= 1'b0;
    end else if (in_acc) begin
      pos_q  <= pos_eff;
      upd_q  <= in_i.want_output || fb_on;
      want_q <= in_i.want_output;
      has_q  <= in_i.has_input;
    end else if (fin_go) begin
      pos_q <= (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= in_i.has_input ? in_i.sample_in : '0;
  end

  // --- delay memory --------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] mem [MAX_DELAY];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic                          mem_we;
  logic [POS_W-1:0]              mem_wa;
  logic signed [SAMPLE_BITS-1:0] mem_wd;
  logic signed [SAMPLE_BITS-1:0] line_val;

  assign mem_we = clr_busy_q || (fin_go && (upd_q || has_q));
  assign mem_wa = clr_busy_q ? clr_cnt_q : pos_q;
  assign mem_wd = clr_busy_q ? '0 : line_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (in_acc) rd_q <= mem[pos_eff];
  end

  // --- datapath: shared multiplier and accumulator -------------------------
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [HIST_W-1:0] ih1_q, ih2_q, oh1_q, oh2_q;
  logic signed [HIST_W-1:0] o_q;
  logic signed [FBT_W-1:0]  fbt_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul)
      MUL_B0_D: begin
        mul_a = MUL_W'(coef_q[0]);
        mul_b = MUL_W'(rd_q);
      end
      MUL_B1_IH1: begin
        mul_a = MUL_W'(coef_q[1]);
        mul_b = MUL_W'(ih1_q);
      end
      MUL_B2_IH2: begin
        mul_a = MUL_W'(coef_q[2]);
        mul_b = MUL_W'(ih2_q);
      end
      MUL_FB1_OH1: begin
        mul_a = MUL_W'(coef_q[3]);
        mul_b = MUL_W'(oh1_q);
      end
      MUL_FB2_OH2: begin
        mul_a = MUL_W'(coef_q[4]);
        mul_b = MUL_W'(oh2_q);
      end
      MUL_FB_O: begin
        mul_a = MUL_W'(fb_s);
        mul_b = MUL_W'(o_q);
      end
      MUL_WET_O: begin
        mul_a = MUL_W'(signed'({1'b0, wetl_q}));
        mul_b = MUL_W'(o_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cw.mul != MUL_NONE) prod_q <= mul_a * mul_b;
    case (cw.acc)
      ACC_LOAD: acc_q <= ACC_W'(prod_q);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
      ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_q);
      default:  ;
    endcase
  end

  // Filter output: round half up at the Q point, saturate to history width.
  localparam logic signed [ACC_W-1:0] O_RND =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [OSH_W-1:0]  o_wide;
  logic signed [HIST_W-1:0] o_sat;

  assign acc_rnd = acc_q + O_RND;
  assign o_wide  = acc_rnd[ACC_W-1:COEF_FRAC_BITS];

  always_comb begin
    if (o_wide[OSH_W-1:HIST_W-1] == {(OSH_W-HIST_W+1){o_wide[OSH_W-1]}}) begin
      o_sat = o_wide[HIST_W-1:0];
    end else if (o_wide[OSH_W-1]) begin
      o_sat = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      o_sat = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih1_q <= '0;
      ih2_q <= '0;
      oh1_q <= '0;
      oh2_q <= '0;
    end else if (cw.calc_o) begin
      ih2_q <= ih1_q;
      ih1_q <= HIST_W'(rd_q);
      oh2_q <= oh1_q;
      oh1_q <= o_sat;
    end
  end

  // Feedback term: round(fb * o / 64), half up.
  logic signed [PROD_W-1:0] prod_r6, prod_r7;
  assign prod_r6 = prod_q + PROD_W'(32);
  assign prod_r7 = prod_q + PROD_W'(64);

  always_ff @(posedge clk_i) begin
    if (cw.calc_o)   o_q   <= o_sat;
    if (cw.calc_fbt) fbt_q <= prod_r6[FBT_W+5:6];
  end

  // Line write: feedback term plus input, saturated.
  logic signed [FBT_W-1:0] fbt_use;
  logic signed [FBT_W:0]   lsum;
  assign fbt_use = fb_on ? fbt_q : '0;
  assign lsum    = (FBT_W+1)'(fbt_use) + (FBT_W+1)'(x_q);

  always_comb begin
    if (lsum[FBT_W:SAMPLE_BITS-1] == {(FBT_W-SAMPLE_BITS+2){lsum[FBT_W]}}) begin
      line_val = lsum[SAMPLE_BITS-1:0];
    end else if (lsum[FBT_W]) begin
      line_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      line_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // Wet term: round(wet * o / 128), half up, saturated; zero if not wanted.
  logic signed [WV_W-1:0]        wv;
  logic signed [SAMPLE_BITS-1:0] wet_sat;
  assign wv = prod_r7[WV_W+6:7];

  always_comb begin
    if (wv[WV_W-1:SAMPLE_BITS-1] == {(WV_W-SAMPLE_BITS+1){wv[WV_W-1]}}) begin
      wet_sat = wv[SAMPLE_BITS-1:0];
    end else if (wv[WV_W-1]) begin
      wet_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      wet_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // --- output register -----------------------------------------------------
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] wet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_go) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) wet_q <= want_q ? wet_sat : '0;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.wet_out = wet_q;

`ifndef SYNTHESIS
  a_no_beat_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !clr_busy_q)
    else $error("input beat taken during clearing pass");

  a_out_only_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(step_q) == STEP_FIN))
    else $error("output beat raised outside final step");

  a_hist_hold_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_IDLE + STEP_W'(1) && !upd_q) |=> $stable(oh1_q) && $stable(ih1_q))
    else $error("filter history changed on a bypassed beat");

  a_fin_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_FIN && out_vld_q && !out_o.ready) |=> $stable(wet_q))
    else $error("pending output overwritten while stalled");
`endif

endmodule
